@@ hw/rtl/met_pkg.sv @@
package met_pkg;

    // Default geometry of the fixed-point coordinates (Q4.28).
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;

    // Iteration count and limit register.
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd500;

    // Which product the shared multiplier is working on.
    typedef enum logic [1:0] {
        OP_XX = 2'd0,
        OP_YY = 2'd1,
        OP_XY = 2'd2
    } met_op_t;

    // Tag that travels with one partial product through the multiplier.
    typedef struct packed {
        met_op_t    op;
        logic [1:0] shift;
    } met_tag_t;

endpackage

@@ hw/rtl/met_point_if.sv @@
interface met_point_if #(
    parameter int COORD_WIDTH = met_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] c_re;
    logic signed [COORD_WIDTH-1:0] c_im;

    modport source (output valid, output c_re, output c_im, input ready);
    modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

@@ hw/rtl/met_result_if.sv @@
interface met_result_if;
    logic                            valid;
    logic                            ready;
    logic [met_pkg::COUNT_W-1:0]     escape_count;
    logic                            in_set;

    modport source (output valid, output escape_count, output in_set, input ready);
    modport sink   (input valid, input escape_count, input in_set, output ready);
endinterface

@@ hw/rtl/met_mul_unit.sv @@
module met_mul_unit #(
    parameter int CH_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    issue,
    input  logic [CH_WIDTH-1:0]     a,
    input  logic [CH_WIDTH-1:0]     b,
    input  met_pkg::met_tag_t       tag_in,
    output logic                    pp_vld,
    output logic [2*CH_WIDTH-1:0]   pp,
    output met_pkg::met_tag_t       tag_out
);
    import met_pkg::*;

    logic                  vld_reg;
    logic [2*CH_WIDTH-1:0] prod_reg;
    met_tag_t              tag_reg;

    // Valid flag of the product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= issue;
        end
    end

    // One unsigned chunk product per cycle, registered with its tag.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= a * b;
            tag_reg  <= tag_in;
        end
    end

    assign pp_vld  = vld_reg;
    assign pp      = prod_reg;
    assign tag_out = tag_reg;

endmodule

@@ hw/rtl/mandelbrot_escape_time_top.sv @@
// Mandelbrot escape-time unit.
// The point channel takes one complex point c (c_re, c_im, signed fixed point
// with FRAC_BITS fraction bits). The unit iterates z = z*z + c from z = c and
// returns on the result channel the step at which |z|^2 >= 4 first held, or
// max_iter with in_set high if it never did. max_iter is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the unit is idle,
// as the block itself does not enforce this. It resets to 500.
// Each iteration runs on the shared multiplier in steps: a magnitude step,
// 3*P multiply issues plus one drain step, the escape test and the update,
// where P is the number of chunk products per square (1 for coordinates up to
// 32 bits, 4 for up to 64 bits). A max_iter of zero finishes a point at once,
// with no iteration.
// The unit takes one point at a time. A finished result waits in an output
// register; a new point is accepted while it waits, and the unit holds its
// finished count if the receiver still stalls when the next result is ready.
// Reset clears all control state and loads max_iter with its default.
module mandelbrot_escape_time_top #(
    parameter int COORD_WIDTH = met_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = met_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [met_pkg::COUNT_W-1:0] cfg_wr_data,
    met_point_if.sink                   point,
    met_result_if.source                result
);
    import met_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int NCH  = (W + 31) / 32;
    localparam int CH   = (W + NCH - 1) / NCH;
    localparam int MW   = NCH * CH;
    localparam int NPP  = NCH * NCH;
    localparam int PW   = (NPP > 1) ? $clog2(NPP) : 1;
    localparam int AW   = 2 * MW;
    localparam int DW   = AW + 1;
    localparam int SW   = DW + 1;
    localparam int CMPW = (AW + 1 > 2 * FRAC_BITS + 3) ? AW + 1 : 2 * FRAC_BITS + 3;
    localparam logic [CMPW-1:0] FOUR = {{(CMPW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);
    localparam logic [PW-1:0]   LAST_PART = PW'(NPP - 1);
    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PREP   = 5'b00010,
        S_MUL    = 5'b00100,
        S_CHECK  = 5'b01000,
        S_UPDATE = 5'b10000
    } met_state_t;

    // Control registers.
    met_state_t         state_reg, state_next;
    logic               fin_reg, fin_next;
    logic [COUNT_W-1:0] max_iter_reg, max_iter_next;
    logic [COUNT_W-1:0] iter_reg, iter_next;
    met_op_t            op_reg, op_next;
    logic [PW-1:0]      part_reg, part_next;
    logic               iss_done_reg, iss_done_next;
    logic               res_valid_reg, res_valid_next;

    // Datapath registers.
    logic signed [W-1:0]  c_re_reg, c_im_reg, x_reg, y_reg, x_next, y_next;
    logic [W-1:0]         ax_reg, ay_reg, ax_next, ay_next;
    logic [AW-1:0]        xx_reg, yy_reg, xy_reg, xx_next, yy_next, xy_next;
    logic signed [DW-1:0] diff_reg, cross_reg, diff_next, cross_next;
    logic [COUNT_W-1:0]   fin_count_reg, fin_count_next;
    logic                 fin_in_set_reg, fin_in_set_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;
    logic                 res_in_set_reg, res_in_set_next;

    // Multiplier interface.
    logic                issue;
    logic [CH-1:0]       mul_a, mul_b;
    met_tag_t            tag_in, tag_out;
    logic                pp_vld;
    logic [2*CH-1:0]     pp;
    logic [PW-1:0]       ia, jb;
    logic [MW-1:0]       a_pad, b_pad;
    logic [AW-1:0]       pp_shifted;

    // Escape test and update terms.
    logic [CMPW-1:0]      mag_sum;
    logic signed [DW-1:0] cross_pos;
    logic signed [SW-1:0] sum_re, sum_im;
    logic                 accept, slot_free;

    assign accept    = point.valid && point.ready;
    assign slot_free = !res_valid_reg || result.ready;

    // Chunk selection for the current partial product.
    always_comb
    begin
        ia     = PW'(part_reg / NCH);
        jb     = PW'(part_reg % NCH);
        a_pad  = (op_reg == OP_YY) ? MW'(ay_reg) : MW'(ax_reg);
        b_pad  = (op_reg == OP_XX) ? MW'(ax_reg) : MW'(ay_reg);
        mul_a  = CH'(a_pad >> (ia * CH));
        mul_b  = CH'(b_pad >> (jb * CH));
        tag_in.op    = op_reg;
        tag_in.shift = 2'(ia) + 2'(jb);
        issue  = (state_reg == S_MUL) && !iss_done_reg;
    end

    met_mul_unit #(
        .CH_WIDTH (CH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .a       (mul_a),
        .b       (mul_b),
        .tag_in  (tag_in),
        .pp_vld  (pp_vld),
        .pp      (pp),
        .tag_out (tag_out)
    );

    // Escape test and next z, from the registered squares and differences.
    always_comb
    begin
        pp_shifted = AW'(pp) << (tag_out.shift * CH);
        mag_sum    = CMPW'(xx_reg) + CMPW'(yy_reg);
        cross_pos  = $signed({xy_reg, 1'b0});
        sum_re     = (SW'(diff_reg) >>> FRAC_BITS) + SW'(c_re_reg);
        sum_im     = (SW'(cross_reg) >>> FRAC_BITS) + SW'(c_im_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        fin_next        = fin_reg;
        max_iter_next   = max_iter_reg;
        iter_next       = iter_reg;
        op_next         = op_reg;
        part_next       = part_reg;
        iss_done_next   = iss_done_reg;
        res_valid_next  = res_valid_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        xx_next         = xx_reg;
        yy_next         = yy_reg;
        xy_next         = xy_reg;
        diff_next       = diff_reg;
        cross_next      = cross_reg;
        fin_count_next  = fin_count_reg;
        fin_in_set_next = fin_in_set_reg;
        res_count_next  = res_count_reg;
        res_in_set_next = res_in_set_reg;

        if (cfg_wr_en)
        begin
            max_iter_next = cfg_wr_data;
        end

        // Accumulate chunk products into the square being formed.
        if (pp_vld)
        begin
            case (tag_out.op)
                OP_XX:   xx_next = xx_reg + pp_shifted;
                OP_YY:   yy_next = yy_reg + pp_shifted;
                OP_XY:   xy_next = xy_reg + pp_shifted;
                default: xy_next = xy_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next    = point.c_re;
                    y_next    = point.c_im;
                    iter_next = '0;
                    if (max_iter_reg == '0)
                    begin
                        fin_count_next  = '0;
                        fin_in_set_next = 1'b1;
                        fin_next        = 1'b1;
                    end
                    else
                    begin
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                ax_next       = x_reg[W-1] ? W'(-x_reg) : W'(x_reg);
                ay_next       = y_reg[W-1] ? W'(-y_reg) : W'(y_reg);
                xx_next       = '0;
                yy_next       = '0;
                xy_next       = '0;
                op_next       = OP_XX;
                part_next     = '0;
                iss_done_next = 1'b0;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                if (iss_done_reg)
                begin
                    state_next = S_CHECK;
                end
                else if (part_reg == LAST_PART)
                begin
                    part_next = '0;
                    case (op_reg)
                        OP_XX:   op_next = OP_YY;
                        OP_YY:   op_next = OP_XY;
                        default: iss_done_next = 1'b1;
                    endcase
                end
                else
                begin
                    part_next = part_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (mag_sum >= FOUR)
                begin
                    fin_count_next  = iter_reg;
                    fin_in_set_next = 1'b0;
                    fin_next        = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    diff_next  = $signed({1'b0, xx_reg}) - $signed({1'b0, yy_reg});
                    cross_next = (x_reg[W-1] != y_reg[W-1]) ? -cross_pos : cross_pos;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // Saturate the new z to the coordinate range.
                if ((&sum_re[SW-1:W-1]) || !(|sum_re[SW-1:W-1]))
                begin
                    x_next = sum_re[W-1:0];
                end
                else
                begin
                    x_next = sum_re[SW-1] ? COORD_MIN : COORD_MAX;
                end
                if ((&sum_im[SW-1:W-1]) || !(|sum_im[SW-1:W-1]))
                begin
                    y_next = sum_im[W-1:0];
                end
                else
                begin
                    y_next = sum_im[SW-1] ? COORD_MIN : COORD_MAX;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_next == max_iter_reg)
                begin
                    fin_count_next  = max_iter_reg;
                    fin_in_set_next = 1'b1;
                    fin_next        = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register: drain on ready, load a finished result when free.
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (fin_reg && slot_free)
        begin
            res_valid_next  = 1'b1;
            res_count_next  = fin_count_reg;
            res_in_set_next = fin_in_set_reg;
            fin_next        = 1'b0;
        end
    end

    // A new point is taken only when no finished result is held back.
    assign point.ready = (state_reg == S_IDLE) && !fin_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_reg       <= 1'b0;
            max_iter_reg  <= MAX_ITER_RESET;
            iter_reg      <= '0;
            op_reg        <= OP_XX;
            part_reg      <= '0;
            iss_done_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            max_iter_reg  <= max_iter_next;
            iter_reg      <= iter_next;
            op_reg        <= op_next;
            part_reg      <= part_next;
            iss_done_reg  <= iss_done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath state.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c_re_reg <= point.c_re;
            c_im_reg <= point.c_im;
        end
        x_reg          <= x_next;
        y_reg          <= y_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        xx_reg         <= xx_next;
        yy_reg         <= yy_next;
        xy_reg         <= xy_next;
        diff_reg       <= diff_next;
        cross_reg      <= cross_next;
        fin_count_reg  <= fin_count_next;
        fin_in_set_reg <= fin_in_set_next;
        res_count_reg  <= res_count_next;
        res_in_set_reg <= res_in_set_next;
    end

    assign result.valid        = res_valid_reg;
    assign result.escape_count = res_count_reg;
    assign result.in_set       = res_in_set_reg;

    // An accepted point either starts iterating or finishes at once.
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PREP) || fin_reg)
        else $error("accepted point did not start or finish");

    // Chunk products only come back while the multiply phase runs.
    a_pp_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        pp_vld |-> (state_reg == S_MUL))
        else $error("partial product outside multiply phase");

    // The escape test only follows a fully drained multiply phase.
    a_check_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> $past(iss_done_reg) && $past(state_reg == S_MUL))
        else $error("escape test before squares were complete");

    // The output register is only loaded from a finished computation.
    a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(fin_reg))
        else $error("result appeared without a finished point");

endmodule

@@ sim/tb_mandelbrot_escape_time_top.sv @@
module tb_mandelbrot_escape_time_top;
    import met_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    // Exact products of two coordinates plus headroom for the sum of squares.
    localparam int PW = 2 * CW + 4;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 50;
    localparam int NUM_DIRECTED = 20;

    // One expected escape result, with the point that caused it.
    typedef struct {
        logic signed [CW-1:0] c_re;
        logic signed [CW-1:0] c_im;
        logic [COUNT_W-1:0]   count;
        logic                 in_set;
    } escape_result_t;

    // Predicts the escape count of each accepted point and checks the results in order.
    class escape_tracker;
        logic [COUNT_W-1:0] limit;
        escape_result_t     pending_counts[$];
        int                 errors;
        int                 points_seen;
        int                 in_set_seen;

        function new();
            limit = MAX_ITER_RESET;
            errors = 0;
            points_seen = 0;
            in_set_seen = 0;
        endfunction

        // Iterates z = z*z + c from z = c with exact products and saturated coordinates.
        function escape_result_t escape_time(logic signed [CW-1:0] cr, logic signed [CW-1:0] ci);
            logic signed [PW-1:0] x, y, xx, yy, nre, nim, four, top, bottom;
            escape_result_t r;
            int i;
            four = PW'(1);
            four = four <<< (2 * FB + 2);
            top = PW'(1);
            top = (top <<< (CW - 1)) - 1;
            bottom = -top - 1;
            x = PW'(cr);
            y = PW'(ci);
            r.c_re = cr;
            r.c_im = ci;
            r.count = limit;
            r.in_set = 1'b1;
            for (i = 0; i < limit; i++)
            begin
                xx = x * x;
                yy = y * y;
                if (xx + yy >= four)
                begin
                    r.count = i[COUNT_W-1:0];
                    r.in_set = 1'b0;
                    return r;
                end
                nre = ((xx - yy) >>> FB) + PW'(cr);
                nim = ((x * y) <<< 1);
                nim = (nim >>> FB) + PW'(ci);
                x = (nre > top) ? top : ((nre < bottom) ? bottom : nre);
                y = (nim > top) ? top : ((nim < bottom) ? bottom : nim);
            end
            return r;
        endfunction

        function void note_point(logic signed [CW-1:0] cr, logic signed [CW-1:0] ci);
            pending_counts.push_back(escape_time(cr, ci));
            points_seen++;
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction

        task report(string what);
            errors++;
            $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_result(logic [COUNT_W-1:0] count, logic in_set);
            escape_result_t want;
            if (in_set === 1'b1)
                in_set_seen++;
            if (pending_counts.size() == 0)
            begin
                report($sformatf("result with nothing pending: count=%0d in_set=%b",
                                 count, in_set));
                return;
            end
            want = pending_counts.pop_front();
            if (count !== want.count)
                report($sformatf("c=(%0d,%0d) limit=%0d: escape_count %0d, want %0d",
                                 want.c_re, want.c_im, limit, count, want.count));
            if (in_set !== want.in_set)
                report($sformatf("c=(%0d,%0d) limit=%0d: in_set %b, want %b",
                                 want.c_re, want.c_im, limit, in_set, want.in_set));
        endtask

        task check_drained();
            if (pending_counts.size() > 0)
                report($sformatf("%0d results never arrived", pending_counts.size()));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [COUNT_W-1:0]  cfg_wr_data;
    escape_tracker       tracker;
    int                  cycles;
    int                  limit_settings;

    // Corner points in Q4.28: the extremes, the radius-two circle and known interior points.
    int directed_re[NUM_DIRECTED] = '{
        0, 32'sh8000_0000, 2147483647, 2147483647, 536870912,
        -536870912, -536870911, -268435456, 0, 67108864,
        69793218, -201326592, 402653184, 134217728, -1,
        1, 1431655765, -26843546, -469762048, 0
    };
    int directed_im[NUM_DIRECTED] = '{
        0, 32'sh8000_0000, 2147483647, 32'sh8000_0000, 0,
        0, 0, 0, 268435456, 0,
        0, 26843546, 402653184, 134217728, -1,
        -1, -1431655766, 174483046, 0, -536870912
    };

    met_point_if #(.COORD_WIDTH(CW)) point_ch();
    met_result_if                    result_ch();

    mandelbrot_escape_time_top #(
        .COORD_WIDTH(CW),
        .FRAC_BITS  (FB)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .point      (point_ch.sink),
        .result     (result_ch.source)
    );

    // Clock with a period of 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short idle gaps, now and then a long one.
    function int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Presents one point after a random gap and waits until the item is taken.
    task send_point(input logic signed [CW-1:0] cr, input logic signed [CW-1:0] ci);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            point_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_ch.valid = 1'b1;
        point_ch.c_re = cr;
        point_ch.c_im = ci;
        @(posedge clk);
        while (!point_ch.ready)
            @(posedge clk);
        tracker.note_point(cr, ci);
        @(negedge clk);
    endtask

    // Holds the point channel until every pending result has come back.
    task wait_idle();
        point_ch.valid = 1'b0;
        while (tracker.pending() > 0)
            @(negedge clk);
    endtask

    task set_limit(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        tracker.limit = value;
        limit_settings++;
    endtask

    // Mixes points around the set, points near the real axis, small points and raw bit patterns.
    task random_point(output logic signed [CW-1:0] cr, output logic signed [CW-1:0] ci);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            cr = $signed($urandom_range(0, 805306368)) - 603979776;
            ci = $signed($urandom_range(0, 805306368)) - 402653184;
        end
        else if (r < 70)
        begin
            cr = $signed($urandom_range(0, 603979776)) - 536870912;
            ci = $signed($urandom_range(0, 2048)) - 1024;
        end
        else if (r < 80)
        begin
            cr = $signed($urandom_range(0, 67108864)) - 33554432;
            ci = $signed($urandom_range(0, 67108864)) - 33554432;
        end
        else
        begin
            cr = $urandom;
            ci = $urandom;
        end
    endtask

    // Results are checked at the rising edge where they are taken.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_result(result_ch.escape_count, result_ch.in_set);
    end

    // Result receiver: random stalls between runs of ready.
    initial
    begin
        int hold;
        result_ch.ready = 1'b0;
        forever
        begin
            hold = idle_length();
            if (hold > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // Ends the run as failed if it has not finished by CYCLE_LIMIT.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles without finishing", cycles);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence: corner points, then random points under a series of limits.
    initial
    begin
        logic signed [CW-1:0] cr, ci;
        logic [COUNT_W-1:0]   lim;
        tracker = new();
        limit_settings = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        point_ch.valid = 1'b0;
        point_ch.c_re = '0;
        point_ch.c_im = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Corner points under the reset limit.
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_point(directed_re[i], directed_im[i]);

        // A zero limit performs no test at all.
        set_limit(16'd0);
        send_point(0, 0);
        send_point(2147483647, 32'sh8000_0000);
        send_point(268435456, 0);

        set_limit(16'd1);
        send_point(0, 0);
        send_point(536870912, 0);
        send_point(-1, -1);

        // Largest limit: one full-length point in the set and two that escape.
        set_limit(16'hFFFF);
        send_point(0, 0);
        send_point(69793218, 0);
        send_point(32'sh8000_0000, 0);

        // Random phases, mostly at small limits so that points in the set stay short.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                lim = 16'd1;
            else if (p == PHASES - 1)
                lim = 16'd300;
            else if (p == PHASES / 2)
                lim = 16'($urandom_range(81, 160));
            else
                lim = 16'($urandom_range(2, 80));
            set_limit(lim);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Now and then the sender holds off until the block has drained.
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 99) < 2)
                    wait_idle();
                random_point(cr, ci);
                send_point(cr, ci);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        tracker.check_drained();

        $display("Checked %0d points under %0d limit settings from 0 to 65535.",
                 tracker.points_seen, limit_settings + 1);
        $display("%0d of the results reported a point inside the set.", tracker.in_set_seen);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/met_pkg.sv
hw/rtl/met_point_if.sv
hw/rtl/met_result_if.sv
hw/rtl/met_mul_unit.sv
hw/rtl/mandelbrot_escape_time_top.sv
sim/tb_mandelbrot_escape_time_top.sv
